// ===== sv/ola_pkg.sv =====
// Shared types, register indexes and saturation helper for the overlap-add block.
`timescale 1ns / 1ps
package ola_pkg;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int NCH_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_RATIO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_LEN_RST    = 11'd512;
  localparam logic [CFG_W-1:0] HOP_RATIO_RST    = 11'd2;
  localparam logic [NCH_W-1:0] NUM_CHANNELS_RST = 3'd1;

  // Payload widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 24;
  localparam int OCH_W = 2;

  localparam logic signed [OUT_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] SAT_MIN = 24'sh800000;

  // Control handed from the sequencer to the datapath
  typedef struct packed {
    logic running;  // geometry valid, store cleared
    logic restart;  // register write: rewind block position
    logic clr_we;   // clearing pass writes zero this cycle
  } ctl_t;

  // Clamp a 25-bit sum to the 24-bit signed range
  function automatic logic signed [OUT_W-1:0] sat24(input logic signed [OUT_W:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > $signed({SAT_MAX[OUT_W-1], SAT_MAX})) r = SAT_MAX;
    else if (v < $signed({SAT_MIN[OUT_W-1], SAT_MIN})) r = SAT_MIN;
    else r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage

// ===== sv/ola_div.sv =====
// Restoring divider, one quotient bit per cycle, for the hop geometry.
`timescale 1ns / 1ps
module ola_div #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     div_r, div_nxt;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             fits;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign fits    = shifted >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/ola_ctrl.sv =====
// Configuration registers, store clearing pass and hop geometry sequencer.
`timescale 1ns / 1ps
module ola_ctrl
  import ola_pkg::*;
#(
  parameter int MAX_FRAME    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [CFG_IDX_W-1:0]                     cfg_index,
  input  logic [CFG_W-1:0]                         cfg_data,
  output ctl_t                                     ctl,
  output logic [$clog2(MAX_CHANNELS*MAX_FRAME)-1:0] clr_addr,
  output logic [$clog2(MAX_FRAME+1)-1:0]           n_eff,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]        c_eff,
  output logic [$clog2(MAX_FRAME+1)-1:0]           hop,
  output logic [$clog2(MAX_FRAME+1)-1:0]           len,
  output logic [$clog2(MAX_FRAME+1)-1:0]           hopmod
);

  localparam int FW    = $clog2(MAX_FRAME + 1);
  localparam int CCW   = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH = MAX_CHANNELS * MAX_FRAME;
  localparam int AW    = $clog2(DEPTH);
  localparam int DIVW  = (FW > CFG_W) ? FW : CFG_W;

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_HOP_GO   = 6'b000010,
    S_HOP_WAIT = 6'b000100,
    S_MOD_GO   = 6'b001000,
    S_MOD_WAIT = 6'b010000,
    S_RUN      = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [CFG_W-1:0]  frame_len_r, frame_len_nxt;
  logic [CFG_W-1:0]  hop_ratio_r, hop_ratio_nxt;
  logic [NCH_W-1:0]  num_ch_r, num_ch_nxt;
  logic [FW-1:0]     hop_r, hop_nxt;
  logic [FW-1:0]     len_r, len_nxt;
  logic [FW-1:0]     hopmod_r, hopmod_nxt;
  logic              cfg_hit;
  logic [CFG_W-1:0]  r_eff;
  logic              div_start;
  logic [DIVW-1:0]   div_a, div_b, div_q, div_rem;
  logic              div_done;

  // Decode register writes
  always_comb begin
    cfg_hit       = 1'b0;
    frame_len_nxt = frame_len_r;
    hop_ratio_nxt = hop_ratio_r;
    num_ch_nxt    = num_ch_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_LEN: begin
          cfg_hit       = 1'b1;
          frame_len_nxt = cfg_data;
        end
        REG_HOP_RATIO: begin
          cfg_hit       = 1'b1;
          hop_ratio_nxt = cfg_data;
        end
        REG_NUM_CHANNELS: begin
          cfg_hit    = 1'b1;
          num_ch_nxt = cfg_data[NCH_W-1:0];
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // Clamp register values to their working ranges
  always_comb begin
    if (frame_len_r == '0) n_eff = FW'(1);
    else if (32'(frame_len_r) > 32'(MAX_FRAME)) n_eff = FW'(MAX_FRAME);
    else n_eff = FW'(frame_len_r);

    if (num_ch_r == '0) c_eff = CCW'(1);
    else if (32'(num_ch_r) > 32'(MAX_CHANNELS)) c_eff = CCW'(MAX_CHANNELS);
    else c_eff = CCW'(num_ch_r);

    r_eff = (hop_ratio_r == '0) ? CFG_W'(1) : hop_ratio_r;
  end

  // Sequence: clear the store, then hop = n / r, then hop mod len
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    hop_nxt     = hop_r;
    len_nxt     = len_r;
    hopmod_nxt  = hopmod_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = S_HOP_GO;
      end
      S_HOP_GO: begin
        state_nxt = S_HOP_WAIT;
      end
      S_HOP_WAIT: begin
        if (div_done) begin
          hop_nxt   = FW'(div_q);
          len_nxt   = n_eff - FW'(div_q);
          state_nxt = S_MOD_GO;
        end
      end
      S_MOD_GO: begin
        state_nxt = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (div_done) begin
          hopmod_nxt = FW'(div_rem);
          state_nxt  = S_RUN;
        end
      end
      S_RUN: begin
        state_nxt = S_RUN;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    // A register write reworks the geometry; the clearing pass runs on
    if (cfg_hit && state_r != S_CLEAR) state_nxt = S_HOP_GO;
  end

  assign div_start = (state_r == S_HOP_GO) || (state_r == S_MOD_GO);
  assign div_a     = (state_r == S_MOD_GO) ? DIVW'(hop_r) : DIVW'(n_eff);
  assign div_b     = (state_r == S_MOD_GO) ? DIVW'(len_r) : DIVW'(r_eff);

  ola_div #(
    .W (DIVW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      frame_len_r <= FRAME_LEN_RST;
      hop_ratio_r <= HOP_RATIO_RST;
      num_ch_r    <= NUM_CHANNELS_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      frame_len_r <= frame_len_nxt;
      hop_ratio_r <= hop_ratio_nxt;
      num_ch_r    <= num_ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hop_r    <= hop_nxt;
    len_r    <= len_nxt;
    hopmod_r <= hopmod_nxt;
  end

  assign ctl.running = (state_r == S_RUN);
  assign ctl.restart = cfg_hit;
  assign ctl.clr_we  = (state_r == S_CLEAR);
  assign clr_addr    = clr_cnt_r;
  assign hop         = hop_r;
  assign len         = len_r;
  assign hopmod      = hopmod_r;

endmodule

// ===== sv/ola_dp.sv =====
// Overlap store memory, read-add-write pipeline, block counters and output register.
`timescale 1ns / 1ps
module ola_dp
  import ola_pkg::*;
#(
  parameter int MAX_FRAME    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  ctl_t                                      ctl,
  input  logic [$clog2(MAX_CHANNELS*MAX_FRAME)-1:0] clr_addr,
  input  logic [$clog2(MAX_FRAME+1)-1:0]            n_eff,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]         c_eff,
  input  logic [$clog2(MAX_FRAME+1)-1:0]            hop,
  input  logic [$clog2(MAX_FRAME+1)-1:0]            len,
  input  logic [$clog2(MAX_FRAME+1)-1:0]            hopmod,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [IN_W-1:0]                    in_sample,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [OUT_W-1:0]                   out_sample,
  output logic [OCH_W-1:0]                          out_channel,
  output logic                                      out_last_of_hop
);

  localparam int FW    = $clog2(MAX_FRAME + 1);
  localparam int PW    = $clog2(MAX_FRAME);
  localparam int SW    = FW + 1;
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CCW   = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH = MAX_CHANNELS * MAX_FRAME;
  localparam int AW    = $clog2(DEPTH);

  logic signed [OUT_W-1:0] mem [DEPTH];

  // Block position counters
  logic [PW-1:0]  t_r, t_nxt;
  logic [CHW-1:0] ch_r, ch_nxt;
  logic [PW-1:0]  base_r, base_nxt;

  // Stage one: read data and item attributes
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_out_r, s1_store_r, s1_last_r, fwd_r;
  logic [CHW-1:0]          s1_ch_r;
  logic signed [IN_W-1:0]  s1_x_r;
  logic [AW-1:0]           s1_waddr_r;
  logic signed [OUT_W-1:0] rdata_r, fwd_data_r;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_sample_r;
  logic [CHW-1:0]          out_ch_r;
  logic                    out_last_r;

  logic                    accept, s1_go, s1_wr, fwd_hit, load_out;
  logic [FW-1:0]           t_ext, t_inc, wr_log;
  logic                    is_out, in_store, is_last;
  logic [SW-1:0]           rd_sum, wr_sum, b_sum;
  logic [PW-1:0]           rd_phys, wr_phys;
  logic [AW-1:0]           ch_off, rd_addr, wr_addr;
  logic [CCW-1:0]          ch_inc;
  logic signed [OUT_W-1:0] stored, addend, s1_val;
  logic signed [OUT_W:0]   s1_sum;

  // Handshake
  assign s1_go    = s1_valid_r && (!s1_out_r || !out_valid_r || !out_stall);
  assign in_stall = !ctl.running || (s1_valid_r && !s1_go);
  assign accept   = in_valid && !in_stall;
  assign s1_wr    = s1_valid_r && !s1_out_r;
  assign load_out = s1_go && s1_out_r;

  // Classify the position and form ring addresses
  always_comb begin
    t_ext    = FW'(t_r);
    t_inc    = t_ext + FW'(1);
    is_out   = t_ext < hop;
    in_store = t_ext < len;
    is_last  = t_inc == hop;
    wr_log   = t_ext - hop;

    rd_sum  = SW'(base_r) + SW'(t_r);
    rd_phys = (rd_sum >= SW'(len)) ? PW'(rd_sum - SW'(len)) : PW'(rd_sum);
    wr_sum  = SW'(base_r) + SW'(wr_log);
    wr_phys = (wr_sum >= SW'(len)) ? PW'(wr_sum - SW'(len)) : PW'(wr_sum);

    ch_off  = AW'(ch_r) * AW'(MAX_FRAME);
    rd_addr = ch_off + AW'(rd_phys);
    wr_addr = ch_off + AW'(wr_phys);
  end

  // Forward the value being written when the new read hits the same entry
  assign fwd_hit = s1_wr && (s1_waddr_r == rd_addr);

  // Add the stored overlap to the sample and saturate
  always_comb begin
    stored = fwd_r ? fwd_data_r : rdata_r;
    addend = s1_store_r ? stored : '0;
    s1_sum = {addend[OUT_W-1], addend} + {{(OUT_W + 1 - IN_W){s1_x_r[IN_W-1]}}, s1_x_r};
    s1_val = sat24(s1_sum);
  end

  // Advance position, channel and ring base
  always_comb begin
    t_nxt    = t_r;
    ch_nxt   = ch_r;
    base_nxt = base_r;
    ch_inc   = CCW'(ch_r) + CCW'(1);
    b_sum    = SW'(base_r) + SW'(hopmod);
    if (ctl.restart) begin
      t_nxt    = '0;
      ch_nxt   = '0;
      base_nxt = '0;
    end else if (accept) begin
      if (t_inc >= n_eff) begin
        t_nxt = '0;
        if (ch_inc >= c_eff) begin
          ch_nxt = '0;
          if (len == '0) base_nxt = '0;
          else if (b_sum >= SW'(len)) base_nxt = PW'(b_sum - SW'(len));
          else base_nxt = PW'(b_sum);
        end else begin
          ch_nxt = CHW'(ch_inc);
        end
      end else begin
        t_nxt = PW'(t_inc);
      end
    end
  end

  always_comb begin
    if (ctl.restart) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = accept || (s1_valid_r && !s1_go);
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r         <= '0;
      ch_r        <= '0;
      base_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      t_r         <= t_nxt;
      ch_r        <= ch_nxt;
      base_r      <= base_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the item and issue the store read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_out_r   <= is_out;
      s1_store_r <= in_store;
      s1_last_r  <= is_last;
      s1_ch_r    <= ch_r;
      s1_x_r     <= in_sample;
      s1_waddr_r <= wr_addr;
      fwd_r      <= fwd_hit;
      fwd_data_r <= s1_val;
      rdata_r    <= mem[rd_addr];
    end
  end

  // Write back: clearing pass or accumulated overlap
  always_ff @(posedge clk) begin
    if (ctl.clr_we) begin
      mem[clr_addr] <= '0;
    end else if (s1_wr) begin
      mem[s1_waddr_r] <= s1_val;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= s1_val;
      out_ch_r     <= s1_ch_r;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_channel     = OCH_W'(out_ch_r);
  assign out_last_of_hop = out_last_r;

endmodule

// ===== sv/overlap_add_synthesis.sv =====
// Overlap-add resynthesis top level.
//
// Input channel (in_valid / in_stall / in_sample) takes one Q1.15 sample per
// transaction, a block of frame_len samples per channel, channels in turn.
// Output channel (out_valid / out_stall / out_sample, out_channel,
// out_last_of_hop) gives one saturated 24-bit sum for each of the first hop
// positions of a channel's block; later positions only update the store.
// Configuration is a write port (cfg_we, cfg_index, cfg_data): 0 frame_len,
// 1 hop_ratio, 2 num_channels. Each such write rewinds to channel 0, position 0.
// Throughput is one sample per cycle unless out_stall holds the flow: each sample
// reads the overlap memory once and the previous one, if store-only, writes back
// in the same cycle. Output samples pass stage one, then the output register.
// After reset a clearing pass zeroes the MAX_CHANNELS*MAX_FRAME entry store,
// one entry per cycle, then the hop geometry is computed by a bit-serial
// divider; in_stall is high throughout. Every register write repeats the
// geometry step only.
// When out_stall holds a result, store-only samples keep flowing and one more
// output sample is taken; the input then stalls until the output register drains.
`timescale 1ns / 1ps
module overlap_add_synthesis
  import ola_pkg::*;
#(
  parameter int MAX_FRAME    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_sample,
  output logic [OCH_W-1:0]        out_channel,
  output logic                    out_last_of_hop
);

  localparam int FW  = $clog2(MAX_FRAME + 1);
  localparam int CCW = $clog2(MAX_CHANNELS + 1);
  localparam int AW  = $clog2(MAX_CHANNELS * MAX_FRAME);

  ctl_t           ctl;
  logic [AW-1:0]  clr_addr;
  logic [FW-1:0]  n_eff, hop, len, hopmod;
  logic [CCW-1:0] c_eff;

  ola_ctrl #(
    .MAX_FRAME    (MAX_FRAME),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .clr_addr  (clr_addr),
    .n_eff     (n_eff),
    .c_eff     (c_eff),
    .hop       (hop),
    .len       (len),
    .hopmod    (hopmod)
  );

  ola_dp #(
    .MAX_FRAME    (MAX_FRAME),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .clr_addr        (clr_addr),
    .n_eff           (n_eff),
    .c_eff           (c_eff),
    .hop             (hop),
    .len             (len),
    .hopmod          (hopmod),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_channel     (out_channel),
    .out_last_of_hop (out_last_of_hop)
  );

endmodule
